/* rtl/ultrasonic_echo_ranger_macros.svh */
// Assertion macros shared by the echo ranger RTL.
// Used by ultrasonic_echo_ranger.sv; relies on nothing else.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define UER_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("echo ranger check failed");

// Next-cycle implication, checked out of reset.
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("echo ranger sequence check failed");

`endif

/* rtl/uer_pkg.sv */
// Types, codes and constants for the ultrasonic echo ranger.
// Used by ultrasonic_echo_ranger.sv; depends on nothing.
package uer_pkg;

   // Default width of the echo width counter.
   localparam int COUNT_BITS_DEFAULT = 16;

   // Configuration port layout.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_US    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIG_PULSE_US = 1'd1;

   // Register reset values.
   localparam logic [15:0] TIMEOUT_US_RESET    = 16'd38400;
   localparam logic [7:0]  TRIG_PULSE_US_RESET = 8'd10;

   // Command codes; any other code is a plain tick.
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_START   = 2'd1;
   localparam logic [1:0] CMD_CONSUME = 2'd2;

   // Distance scale: mm = (round_time * DIST_MUL) >> DIST_SHIFT.
   localparam logic [13:0] DIST_MUL   = 14'd10882;
   localparam int          DIST_SHIFT = 16;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_TRIG = 3'd1,
      PH_RISE = 3'd2,
      PH_FALL = 3'd3,
      PH_DONE = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_TIMEOUT = 2'd1,
      ERR_NOEDGE  = 2'd2,
      ERR_FAST    = 2'd3
   } err_type;

   // One result word.
   typedef struct packed {
      logic        trig_out;
      logic        measuring;
      logic        available;
      logic [15:0] round_time_us;
      logic [13:0] distance_mm;
      err_type     error_code;
   } rsp_type;

endpackage

/* rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger top level: trigger, echo timing and range result.
// Depends on uer_pkg and ultrasonic_echo_ranger_macros.svh.
//
// Each request word is one microsecond tick carrying a command (tick, start,
// consume) and the sampled echo level. Every accepted request word produces
// exactly one response word giving the trigger pin level, measuring and
// available flags, the last round trip time, the distance in mm and status.
// Configuration words on the csr_ channel set the timeout and trigger length;
// csr_ready is always high and writes belong only to idle periods.
// A response word is registered in the response register, or in the skid
// register while an earlier one waits. Throughput: one word per cycle while
// req_ready is high; state update and multiplier feed the response register.
// The response register is backed by a one-word skid register, so a request
// word is still taken while a response word waits; req_ready drops only once
// both hold words, and comes back as soon as rsp_ready takes one.
// Reset (synchronous, active high) returns the sequencer to idle, clears the
// counters, round time and status, restores the register defaults and
// empties the response path.
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger #(
   parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_command,
   input  logic                               req_echo_level,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_trig_out,
   output logic                               rsp_measuring,
   output logic                               rsp_available,
   output logic [15:0]                        rsp_round_time_us,
   output logic [13:0]                        rsp_distance_mm,
   output logic [1:0]                         rsp_error_code,
   // Configuration channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [uer_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   // Configuration registers
   logic [15:0] timeout_us_ff;
   logic [7:0]  trig_pulse_us_ff;

   // Sequencer state
   uer_pkg::phase_type    phase_ff, phase_in;
   logic                  echo_prev_ff;
   logic [7:0]            pulse_count_ff, pulse_count_in;
   logic [COUNT_BITS-1:0] width_count_ff, width_count_in;
   logic [15:0]           last_round_ff, last_round_in;
   uer_pkg::err_type      status_ff, status_in;

   // Response path
   logic             out_valid_ff, skid_valid_ff;
   uer_pkg::rsp_type out_ff, skid_ff, rsp_new;
   logic             req_accept;
   logic             trig_now;
   logic [29:0]      dist_product;

   assign csr_ready  = 1'b1;
   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_us_ff    <= uer_pkg::TIMEOUT_US_RESET;
         trig_pulse_us_ff <= uer_pkg::TRIG_PULSE_US_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            uer_pkg::CSR_TIMEOUT_US:    timeout_us_ff    <= csr_wdata[15:0];
            uer_pkg::CSR_TRIG_PULSE_US: trig_pulse_us_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Next state for one tick: command handling, then the phase step.
   always_comb begin
      logic [CMP_BITS-1:0] width_ext;
      logic [CMP_BITS-1:0] timeout_ext;
      logic                over_timeout;

      phase_in       = phase_ff;
      pulse_count_in = pulse_count_ff;
      width_count_in = width_count_ff;
      last_round_in  = last_round_ff;
      status_in      = status_ff;
      trig_now       = 1'b0;

      width_ext    = CMP_BITS'(width_count_ff);
      timeout_ext  = CMP_BITS'(timeout_us_ff);
      over_timeout = (width_ext > timeout_ext);

      case (req_command)
         uer_pkg::CMD_START: begin
            case (phase_ff)
               uer_pkg::PH_TRIG, uer_pkg::PH_RISE: begin
                  status_in = uer_pkg::ERR_NOEDGE;
               end
               uer_pkg::PH_FALL: begin
                  status_in = over_timeout ? uer_pkg::ERR_TIMEOUT : uer_pkg::ERR_FAST;
               end
               uer_pkg::PH_DONE: begin
                  if (over_timeout) begin
                     status_in = uer_pkg::ERR_TIMEOUT;
                  end else begin
                     status_in     = uer_pkg::ERR_NONE;
                     last_round_in = width_ext[15:0];
                  end
               end
               default: ;
            endcase
            width_count_in = '0;
            pulse_count_in = '0;
            phase_in       = uer_pkg::PH_TRIG;
         end
         uer_pkg::CMD_CONSUME: begin
            if (phase_ff == uer_pkg::PH_DONE) begin
               if (over_timeout) begin
                  status_in = uer_pkg::ERR_TIMEOUT;
               end else begin
                  status_in     = uer_pkg::ERR_NONE;
                  last_round_in = width_ext[15:0];
               end
               width_count_in = '0;
               phase_in       = uer_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase

      case (phase_in)
         uer_pkg::PH_TRIG: begin
            trig_now       = 1'b1;
            pulse_count_in = pulse_count_in + 8'd1;
            if (pulse_count_in >= trig_pulse_us_ff) begin
               phase_in = uer_pkg::PH_RISE;
            end
         end
         uer_pkg::PH_RISE: begin
            if (req_echo_level && !echo_prev_ff) begin
               width_count_in = COUNT_BITS'(1);
               phase_in       = uer_pkg::PH_FALL;
            end
         end
         uer_pkg::PH_FALL: begin
            if (req_echo_level) begin
               if (width_count_in != '1) begin
                  width_count_in = width_count_in + COUNT_BITS'(1);
               end
            end else begin
               phase_in = uer_pkg::PH_DONE;
            end
         end
         uer_pkg::PH_IDLE, uer_pkg::PH_DONE: ;
         default: phase_in = uer_pkg::PH_IDLE;
      endcase
   end

   // Result word built from the state after this tick.
   assign dist_product = 30'(last_round_in) * 30'(uer_pkg::DIST_MUL);

   always_comb begin
      rsp_new.trig_out      = trig_now;
      rsp_new.measuring     = (phase_in == uer_pkg::PH_TRIG) ||
                              (phase_in == uer_pkg::PH_RISE) ||
                              (phase_in == uer_pkg::PH_FALL);
      rsp_new.available     = (phase_in == uer_pkg::PH_DONE);
      rsp_new.round_time_us = last_round_in;
      rsp_new.distance_mm   = dist_product[uer_pkg::DIST_SHIFT +: 14];
      rsp_new.error_code    = status_in;
   end

   // Sequencer state registers advance once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= uer_pkg::PH_IDLE;
         echo_prev_ff   <= 1'b0;
         pulse_count_ff <= '0;
         width_count_ff <= '0;
         last_round_ff  <= '0;
         status_ff      <= uer_pkg::ERR_NONE;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         echo_prev_ff   <= req_echo_level;
         pulse_count_ff <= pulse_count_in;
         width_count_ff <= width_count_in;
         last_round_ff  <= last_round_in;
         status_ff      <= status_in;
      end
   end

   // Response register with a one-word skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : rsp_new;
      end else if (req_accept) begin
         skid_ff <= rsp_new;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_trig_out      = out_ff.trig_out;
   assign rsp_measuring     = out_ff.measuring;
   assign rsp_available     = out_ff.available;
   assign rsp_round_time_us = out_ff.round_time_us;
   assign rsp_distance_mm   = out_ff.distance_mm;
   assign rsp_error_code    = out_ff.error_code;

   // The skid register only fills behind a held response word.
   `UER_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // A response word never shows the trigger high outside a measurement.
   `UER_ASSERT_NOW(a_trig_in_measure, clock, reset, rsp_valid && rsp_trig_out, rsp_measuring)
   // A finished pulse and a running measurement exclude each other.
   `UER_ASSERT_NOW(a_avail_excl, clock, reset, rsp_valid && rsp_available, !rsp_measuring)
   // A start always leaves the sequencer in the trigger pulse or the rise wait.
   `UER_ASSERT_NEXT(a_start_phase, clock, reset,
      req_accept && (req_command == uer_pkg::CMD_START),
      (phase_ff == uer_pkg::PH_TRIG) || (phase_ff == uer_pkg::PH_RISE))

endmodule
